/* sv/assert_macros.svh */
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define CHK_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define CHK_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* sv/dms_pkg.sv */
package dms_pkg;
  localparam int MAX_LEN   = 512;
  localparam int AW        = $clog2(MAX_LEN);
  localparam int LW        = $clog2(MAX_LEN + 1);
  localparam int SUM_W     = 3 * AW + 1;
  localparam int NUM_W     = SUM_W + 4;
  localparam int PROD_W    = 2 * LW;
  localparam int Q_IT      = 14;
  localparam int DIV_W     = NUM_W + Q_IT;
  localparam int SCORE_W   = 13;
  localparam int SCORE_MAX = 8191;
  localparam int QD        = 4;
  localparam int QAW       = $clog2(QD);

  localparam logic [1:0] REQ_FIRST  = 2'd0;
  localparam logic [1:0] REQ_SECOND = 2'd1;
  localparam logic [1:0] REQ_FINISH = 2'd2;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] char_code;
  } req_t;

  typedef struct packed {
    logic busy;
    logic scanning;
  } back_stat_t;
endpackage

/* sv/diagonal_match_similarity_score.sv */
// Diagonal match similarity score. Append requests (type 0 to the first string,
// type 1 to the second) are taken one per cycle into a four-entry queue unless
// it is full and retire one per cycle, while no finish runs, into two byte
// memories of MAX_LEN entries each; a full string drops the byte and flags
// overflow. A finish request (type 2) walks the la*lb character pairs diagonal
// by diagonal, one pair per cycle through the two memory read ports, squares
// each diagonal count, then divides 10*sum by la*lb with a 14-step restoring
// divider. The queue keeps filling while a scored finish runs; a finish on an
// empty string or after overflow skips the scan and answers with score 0
// (status 1 on overflow). Every finish empties both strings. Type 3 is dropped.
`include "assert_macros.svh"

module diagonal_match_similarity_score import dms_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_req_type,
  input  logic [7:0]         in_char_code,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [SCORE_W-1:0] out_score,
  output logic               out_status
);
  // queue between front and back
  logic       q_vld;
  req_t       q_req;
  logic       q_pop;
  back_stat_t stat;

  // front: request intake and queue
  dms_front u_front (
    .clk, .rst_n,
    .in_valid, .in_stall, .in_req_type, .in_char_code,
    .q_vld, .q_req, .q_pop
  );

  // back: string storage, diagonal scan, divide, result register
  dms_back u_back (
    .clk, .rst_n,
    .q_vld, .q_req, .q_pop, .stat,
    .out_valid, .out_stall, .out_score, .out_status
  );

  // never pop an empty queue
  `CHK_IMPL(a_pop_vld, clk, rst_n, q_pop, q_vld)
  // back takes nothing while a finish is in flight
  `CHK_IMPL(a_busy_nopop, clk, rst_n, stat.busy, !q_pop)
  // the diagonal walk only happens inside a busy finish
  `CHK_IMPL(a_scan_busy, clk, rst_n, stat.scanning, stat.busy)
  // overflow result always carries a zero score
  `CHK_IMPL(a_ovf_zero, clk, rst_n, out_valid && out_status, out_score == '0)
endmodule

/* sv/dms_ram.sv */
module dms_ram #(
  parameter int W     = 8,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [W-1:0]             wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [W-1:0]             rdata
);
  logic [W-1:0] mem [DEPTH];
  logic [W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;
endmodule

/* sv/dms_front.sv */
module dms_front import dms_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_req_type,
  input  logic [7:0] in_char_code,
  output logic       q_vld,
  output req_t       q_req,
  input  logic       q_pop
);
  req_t           fifo_r [QD];
  logic [QAW-1:0] wptr_r, wptr_nxt;
  logic [QAW-1:0] rptr_r, rptr_nxt;
  logic [QAW:0]   cnt_r, cnt_nxt;
  logic           push;

  assign in_stall = (cnt_r == (QAW+1)'(QD));
  assign push     = in_valid && !in_stall;
  assign q_vld    = (cnt_r != '0);
  assign q_req    = fifo_r[rptr_r];

  always_comb begin
    wptr_nxt = push ? wptr_r + 1'b1 : wptr_r;
    rptr_nxt = q_pop ? rptr_r + 1'b1 : rptr_r;
    cnt_nxt  = cnt_r + (QAW+1)'(push) - (QAW+1)'(q_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
    if (push) begin
      fifo_r[wptr_r] <= '{req_type: in_req_type, char_code: in_char_code};
    end
  end
endmodule

/* sv/dms_back.sv */
module dms_back import dms_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_vld,
  input  req_t               q_req,
  output logic               q_pop,
  output back_stat_t         stat,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [SCORE_W-1:0] out_score,
  output logic               out_status
);
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SCAN  = 3'd1;
  localparam logic [2:0] ST_DRAIN = 3'd2;
  localparam logic [2:0] ST_MUL   = 3'd3;
  localparam logic [2:0] ST_DIV   = 3'd4;
  localparam logic [2:0] ST_OUT   = 3'd5;

  logic [2:0]         state_r, state_nxt;
  logic [LW-1:0]      len_a_r, len_a_nxt, len_b_r, len_b_nxt;
  logic               ovf_r, ovf_nxt;
  logic [LW-1:0]      si_r, si_nxt, sj_r, sj_nxt, ci_r, ci_nxt, cj_r, cj_nxt;
  logic               p1_vld_r, p1_vld_nxt, p1_last_r, p1_last_nxt;
  logic [LW-1:0]      cnt_r, cnt_nxt, cnt_cur;
  logic               m_vld_r, m_vld_nxt;
  logic [LW-1:0]      m_val_r, m_val_nxt;
  logic               sq_vld_r;
  logic [2*LW-1:0]    sq_r;
  logic [SUM_W-1:0]   sum_r, sum_nxt;
  logic [1:0]         drain_r, drain_nxt;
  logic [DIV_W-1:0]   rem_r, rem_nxt, dsh_r, dsh_nxt;
  logic [Q_IT-1:0]    q_r, q_nxt;
  logic [$clog2(Q_IT)-1:0] bit_r, bit_nxt;
  logic               ov_r, ov_nxt;
  logic [SCORE_W-1:0] sc_r, sc_nxt;
  logic               st_r, st_nxt;

  logic               slot_free, end_diag, last_all;
  logic               we_a, we_b;
  logic [7:0]         rd_a, rd_b;
  logic [PROD_W-1:0]  prod;

  assign slot_free = !ov_r || !out_stall;
  assign end_diag  = (ci_r == len_a_r - LW'(1)) || (cj_r == len_b_r - LW'(1));
  assign last_all  = end_diag && (sj_r == '0) && (si_r == len_a_r - LW'(1));
  assign cnt_cur   = cnt_r + LW'(rd_a == rd_b);
  assign prod      = PROD_W'(len_a_r) * PROD_W'(len_b_r);

  assign we_a = (state_r == ST_IDLE) && q_pop && (q_req.req_type == REQ_FIRST)
                && (len_a_r != LW'(MAX_LEN));
  assign we_b = (state_r == ST_IDLE) && q_pop && (q_req.req_type == REQ_SECOND)
                && (len_b_r != LW'(MAX_LEN));

  dms_ram #(.W(8), .DEPTH(MAX_LEN)) u_ram_a (
    .clk, .we(we_a), .waddr(len_a_r[AW-1:0]), .wdata(q_req.char_code),
    .raddr(ci_r[AW-1:0]), .rdata(rd_a)
  );
  dms_ram #(.W(8), .DEPTH(MAX_LEN)) u_ram_b (
    .clk, .we(we_b), .waddr(len_b_r[AW-1:0]), .wdata(q_req.char_code),
    .raddr(cj_r[AW-1:0]), .rdata(rd_b)
  );

  always_comb begin
    state_nxt   = state_r;
    len_a_nxt   = len_a_r;
    len_b_nxt   = len_b_r;
    ovf_nxt     = ovf_r;
    si_nxt      = si_r;
    sj_nxt      = sj_r;
    ci_nxt      = ci_r;
    cj_nxt      = cj_r;
    p1_vld_nxt  = 1'b0;
    p1_last_nxt = 1'b0;
    cnt_nxt     = cnt_r;
    m_vld_nxt   = 1'b0;
    m_val_nxt   = m_val_r;
    sum_nxt     = sq_vld_r ? sum_r + SUM_W'(sq_r) : sum_r;
    drain_nxt   = drain_r;
    rem_nxt     = rem_r;
    dsh_nxt     = dsh_r;
    q_nxt       = q_r;
    bit_nxt     = bit_r;
    ov_nxt      = out_stall ? ov_r : 1'b0;
    sc_nxt      = sc_r;
    st_nxt      = st_r;
    q_pop       = 1'b0;

    // diagonal match counting, one stage behind the ram reads
    if (p1_vld_r) begin
      if (p1_last_r) begin
        m_val_nxt = cnt_cur;
        m_vld_nxt = 1'b1;
        cnt_nxt   = '0;
      end else begin
        cnt_nxt = cnt_cur;
      end
    end

    unique case (state_r)
      ST_IDLE: begin
        if (q_vld) begin
          unique case (q_req.req_type)
            REQ_FIRST: begin
              q_pop = 1'b1;
              if (len_a_r == LW'(MAX_LEN)) ovf_nxt = 1'b1;
              else len_a_nxt = len_a_r + LW'(1);
            end
            REQ_SECOND: begin
              q_pop = 1'b1;
              if (len_b_r == LW'(MAX_LEN)) ovf_nxt = 1'b1;
              else len_b_nxt = len_b_r + LW'(1);
            end
            REQ_FINISH: begin
              if (slot_free) begin
                q_pop = 1'b1;
                if (ovf_r || len_a_r == '0 || len_b_r == '0) begin
                  ov_nxt    = 1'b1;
                  sc_nxt    = '0;
                  st_nxt    = ovf_r;
                  len_a_nxt = '0;
                  len_b_nxt = '0;
                  ovf_nxt   = 1'b0;
                end else begin
                  si_nxt    = '0;
                  sj_nxt    = len_b_r - LW'(1);
                  ci_nxt    = '0;
                  cj_nxt    = len_b_r - LW'(1);
                  cnt_nxt   = '0;
                  sum_nxt   = '0;
                  state_nxt = ST_SCAN;
                end
              end
            end
            default: q_pop = 1'b1;
          endcase
        end
      end
      ST_SCAN: begin
        p1_vld_nxt  = 1'b1;
        p1_last_nxt = end_diag;
        if (end_diag) begin
          if (sj_r != '0) begin
            sj_nxt = sj_r - LW'(1);
            si_nxt = '0;
            ci_nxt = '0;
            cj_nxt = sj_r - LW'(1);
          end else begin
            si_nxt = si_r + LW'(1);
            ci_nxt = si_r + LW'(1);
            cj_nxt = '0;
          end
        end else begin
          ci_nxt = ci_r + LW'(1);
          cj_nxt = cj_r + LW'(1);
        end
        if (last_all) begin
          drain_nxt = '0;
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        drain_nxt = drain_r + 2'd1;
        if (drain_r == 2'd2) state_nxt = ST_MUL;
      end
      ST_MUL: begin
        rem_nxt   = DIV_W'({sum_r, 3'b000}) + DIV_W'({sum_r, 1'b0});
        dsh_nxt   = DIV_W'(prod) << (Q_IT - 1);
        q_nxt     = '0;
        bit_nxt   = ($clog2(Q_IT))'(Q_IT - 1);
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (rem_r >= dsh_r) begin
          rem_nxt      = rem_r - dsh_r;
          q_nxt[bit_r] = 1'b1;
        end
        dsh_nxt = dsh_r >> 1;
        bit_nxt = bit_r - 1'b1;
        if (bit_r == '0) state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (slot_free) begin
          ov_nxt    = 1'b1;
          sc_nxt    = (q_r > Q_IT'(SCORE_MAX)) ? SCORE_W'(SCORE_MAX) : q_r[SCORE_W-1:0];
          st_nxt    = 1'b0;
          len_a_nxt = '0;
          len_b_nxt = '0;
          ovf_nxt   = 1'b0;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      len_a_r  <= '0;
      len_b_r  <= '0;
      ovf_r    <= 1'b0;
      p1_vld_r <= 1'b0;
      m_vld_r  <= 1'b0;
      sq_vld_r <= 1'b0;
      ov_r     <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      len_a_r  <= len_a_nxt;
      len_b_r  <= len_b_nxt;
      ovf_r    <= ovf_nxt;
      p1_vld_r <= p1_vld_nxt;
      m_vld_r  <= m_vld_nxt;
      sq_vld_r <= m_vld_r;
      ov_r     <= ov_nxt;
    end
    si_r      <= si_nxt;
    sj_r      <= sj_nxt;
    ci_r      <= ci_nxt;
    cj_r      <= cj_nxt;
    p1_last_r <= p1_last_nxt;
    cnt_r     <= cnt_nxt;
    m_val_r   <= m_val_nxt;
    sq_r      <= (2*LW)'(m_val_r) * (2*LW)'(m_val_r);
    sum_r     <= sum_nxt;
    drain_r   <= drain_nxt;
    rem_r     <= rem_nxt;
    dsh_r     <= dsh_nxt;
    q_r       <= q_nxt;
    bit_r     <= bit_nxt;
    sc_r      <= sc_nxt;
    st_r      <= st_nxt;
  end

  assign stat.busy     = (state_r != ST_IDLE);
  assign stat.scanning = (state_r == ST_SCAN);
  assign out_valid     = ov_r;
  assign out_score     = sc_r;
  assign out_status    = st_r;
endmodule

/* bench/diagonal_match_similarity_score_tb.sv */
`timescale 1ns / 1ps

module diagonal_match_similarity_score_tb;
  import dms_pkg::*;

  localparam int HALF_PERIOD = 10;
  localparam int CYCLE_LIMIT = 3000000;
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] in_req_type = REQ_FIRST;
  logic [7:0] in_char_code = 8'd0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [SCORE_W-1:0] out_score;
  logic out_status;

  typedef struct packed {
    logic [SCORE_W-1:0] score;
    logic status;
  } score_t;

  typedef struct {
    logic [1:0] req;
    logic [7:0] ch;
    bit has_fixed;
    score_t fixed;
  } stim_row_t;

  // predictor state: strings, their lengths and the overflow flag
  logic [7:0] text_a [MAX_LEN];
  logic [7:0] text_b [MAX_LEN];
  int unsigned len_a, len_b;
  bit overflowed;

  score_t pending_scores [$];
  int errors = 0;
  int cycles = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  diagonal_match_similarity_score dut (
    .clk, .rst_n, .in_valid, .in_stall, .in_req_type, .in_char_code,
    .out_valid, .out_stall, .out_score, .out_status
  );

  always #HALF_PERIOD clk = ~clk;

  // squared diagonal histogram score over the two stored strings
  function automatic score_t diagonal_score();
    int unsigned counts [2*MAX_LEN];
    longint unsigned sum, quo;
    score_t r;
    sum = 0;
    r = '0;
    if (overflowed) begin
      r.status = 1'b1;
      return r;
    end
    if (len_a == 0 || len_b == 0) return r;
    foreach (counts[k]) counts[k] = 0;
    for (int i = 0; i < len_a; i++)
      for (int j = 0; j < len_b; j++)
        if (text_a[i] == text_b[j]) counts[len_b - 1 + i - j]++;
    for (int d = 0; d + 1 < len_a + len_b; d++)
      sum += longint'(counts[d]) * counts[d];
    quo = (sum * 10) / (longint'(len_a) * len_b);
    r.score = (quo > SCORE_MAX) ? SCORE_MAX[SCORE_W-1:0] : quo[SCORE_W-1:0];
    return r;
  endfunction

  // advance the predictor by one accepted request
  task automatic predict_request(input logic [1:0] req, input logic [7:0] ch);
    case (req)
      REQ_FIRST: begin
        if (len_a >= MAX_LEN) overflowed = 1'b1;
        else begin
          text_a[len_a] = ch;
          len_a++;
        end
      end
      REQ_SECOND: begin
        if (len_b >= MAX_LEN) overflowed = 1'b1;
        else begin
          text_b[len_b] = ch;
          len_b++;
        end
      end
      REQ_FINISH: begin
        pending_scores.push_back(diagonal_score());
        len_a = 0;
        len_b = 0;
        overflowed = 1'b0;
      end
      default: ;
    endcase
  endtask

  // present one request and hold it until the block takes it
  task automatic send_request(input logic [1:0] req, input logic [7:0] ch);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req_type <= req;
    in_char_code <= ch;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_request(req, ch);
  endtask

  task automatic send_random_string(input logic [1:0] req, input int n,
                                    input int alphabet);
    for (int k = 0; k < n; k++)
      send_request(req, 8'($urandom_range(alphabet - 1)));
  endtask

  // receiver: random stall, compare each result with the oldest expectation
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (pending_scores.size() == 0) begin
          $display("%0t: unexpected result score=%0d status=%0b", $time,
                   out_score, out_status);
          errors++;
        end else begin
          score_t exp_s;
          exp_s = pending_scores.pop_front();
          if (out_score !== exp_s.score) begin
            $display("%0t: score expected %0d actual %0d", $time, exp_s.score, out_score);
            errors++;
          end
          if (out_status !== exp_s.status) begin
            $display("%0t: status expected %0b actual %0b", $time, exp_s.status,
                     out_status);
            errors++;
          end
        end
      end
      out_stall <= (recv_idle_pct > 0) && ($urandom_range(99) < recv_idle_pct);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    stim_row_t rows [$];
    stim_row_t row;
    int n_random, kind;
    len_a = 0;
    len_b = 0;
    overflowed = 1'b0;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table; fixed expectations where obvious
    rows = '{
      '{REQ_FINISH, 8'h00, 1'b1, '{13'd0, 1'b0}},  // empty strings after reset
      '{REQ_FIRST, 8'hff, 1'b0, '0},
      '{REQ_FINISH, 8'h5a, 1'b1, '{13'd0, 1'b0}},  // second string empty
      '{REQ_SECOND, 8'h00, 1'b0, '0},
      '{REQ_FINISH, 8'hff, 1'b1, '{13'd0, 1'b0}},  // first string empty
      '{REQ_FIRST, 8'h00, 1'b0, '0},
      '{REQ_SECOND, 8'h00, 1'b0, '0},
      '{REQ_UNUSED, 8'hff, 1'b0, '0},              // ignored request
      '{REQ_FINISH, 8'h00, 1'b1, '{13'd10, 1'b0}}, // single match: 10*1/1
      '{REQ_FIRST, 8'hff, 1'b0, '0},
      '{REQ_SECOND, 8'h00, 1'b0, '0},
      '{REQ_FINISH, 8'h00, 1'b1, '{13'd0, 1'b0}},  // no match
      '{REQ_FIRST, 8'hff, 1'b0, '0},
      '{REQ_FIRST, 8'hff, 1'b0, '0},
      '{REQ_FIRST, 8'h80, 1'b0, '0},
      '{REQ_SECOND, 8'hff, 1'b0, '0},
      '{REQ_SECOND, 8'h7f, 1'b0, '0},
      '{REQ_FINISH, 8'h00, 1'b0, '0}
    };
    foreach (rows[r]) begin
      row = rows[r];
      send_request(row.req, row.ch);
      if (row.has_fixed && pending_scores[$] != row.fixed) begin
        $display("%0t: directed row %0d expected %0d/%0b predicted %0d/%0b", $time, r,
                 row.fixed.score, row.fixed.status, pending_scores[$].score,
                 pending_scores[$].status);
        errors++;
      end
    end

    // string full: one more than capacity on the first string, then finish
    send_random_string(REQ_FIRST, MAX_LEN + 1, 256);
    send_random_string(REQ_SECOND, 3, 4);
    send_request(REQ_FINISH, 8'h00);
    // full but not overflowing on the second string, all matching
    send_random_string(REQ_FIRST, 20, 1);
    send_random_string(REQ_SECOND, MAX_LEN, 1);
    send_request(REQ_FINISH, 8'h00);

    // random phases with shifting idle pressure
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 35 : (phase == 1) ? 45 : 0;
      recv_idle_pct = (phase == 0) ? 45 : (phase == 1) ? 35 : 0;
      n_random = 0;
      while (n_random < 80) begin
        kind = $urandom_range(99);
        if (kind < 85) begin
          // well-formed pair: short strings, usually a small alphabet for many matches
          int la, lb, alpha;
          la = $urandom_range(12);
          lb = $urandom_range(12);
          alpha = ($urandom_range(3) == 0) ? 256 : $urandom_range(1, 4);
          send_random_string(REQ_FIRST, la, alpha);
          send_random_string(REQ_SECOND, lb, alpha);
          if ($urandom_range(9) == 0) send_request(REQ_UNUSED, 8'($urandom));
          send_request(REQ_FINISH, 8'($urandom));
          n_random += la + lb + 1;
        end else if (kind < 95) begin
          send_request(2'($urandom_range(2)), 8'($urandom));
          n_random++;
        end else begin
          // occasional longer pair
          int la, lb;
          la = $urandom_range(40, 64);
          lb = $urandom_range(40, 64);
          send_random_string(REQ_FIRST, la, 2);
          send_random_string(REQ_SECOND, lb, 2);
          send_request(REQ_FINISH, 8'h00);
          n_random += la + lb + 1;
        end
      end
    end
    // flush any partial strings so nothing is left half loaded
    send_request(REQ_FINISH, 8'h00);
    in_valid <= 1'b0;

    while (pending_scores.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule

/* files.f */
+incdir+sv
sv/dms_pkg.sv
sv/dms_ram.sv
sv/dms_front.sv
sv/dms_back.sv
sv/diagonal_match_similarity_score.sv
bench/diagonal_match_similarity_score_tb.sv
